/* hw/rtl/xyzc_pkg.sv */
// ----------------------------------------------------------------------------
// xyzc_pkg
// Shared widths, register indexes and controller/datapath command types.
// ----------------------------------------------------------------------------
package xyzc_pkg;

    localparam int NumRegs      = 8;
    localparam int RegW         = 16;
    localparam int PixW         = 20;
    localparam int CoefW        = 40;
    localparam int CoefFracBits = 24;
    localparam int RowW         = 35;
    localparam int NormW        = 54;
    localparam int NumW         = 53;
    localparam int QuoW         = 39;
    localparam int DivSteps     = QuoW + 1;
    localparam int AccW         = 64;

    localparam logic [CoefW-1:0] CoefLimit = {1'b0, {(CoefW-1){1'b1}}};

    typedef enum logic [2:0] {
        REG_RED_X   = 3'd0,
        REG_RED_Y   = 3'd1,
        REG_GREEN_X = 3'd2,
        REG_GREEN_Y = 3'd3,
        REG_BLUE_X  = 3'd4,
        REG_BLUE_Y  = 3'd5,
        REG_WHITE_X = 3'd6,
        REG_WHITE_Y = 3'd7
    } reg_idx_t;

    localparam logic [RegW-1:0] RegDefaults [NumRegs] = '{
        16'd42598, 16'd21627, 16'd19661, 16'd39322,
        16'd9830,  16'd3932,  16'd20493, 16'd21569
    };

    // controller -> datapath
    typedef struct packed {
        logic       rows_load;   // register cross products
        logic       norm_load;   // register white dot product of row
        logic       div_start;   // start coefficient division
        logic       div_step;    // one restoring step
        logic       coef_store;  // write quotient into matrix
        logic [1:0] row_sel;
        logic [1:0] col_sel;
        logic       pix_load;    // capture pixel
        logic       mul_go;      // products register
        logic       sum_go;      // sum and shift register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic white_y_zero;
        logic norm_zero;
        logic div_sat;
    } dp_stat_t;

endpackage

/* hw/rtl/xyzc_if.sv */
// ----------------------------------------------------------------------------
// xyzc_if
// Valid/ready channel interfaces for pixels, results and register writes.
// ----------------------------------------------------------------------------
interface xyzc_pix_if;
    logic                        valid;
    logic                        ready;
    logic [xyzc_pkg::PixW-1:0]   cie_x;
    logic [xyzc_pkg::PixW-1:0]   cie_y;
    logic [xyzc_pkg::PixW-1:0]   cie_z;
    modport source (output valid, cie_x, cie_y, cie_z, input ready);
    modport sink   (input valid, cie_x, cie_y, cie_z, output ready);
endinterface

interface xyzc_rgb_if;
    logic                        valid;
    logic                        ready;
    logic [xyzc_pkg::PixW-1:0]   red_out;
    logic [xyzc_pkg::PixW-1:0]   green_out;
    logic [xyzc_pkg::PixW-1:0]   blue_out;
    logic                        degenerate;
    modport source (output valid, red_out, green_out, blue_out, degenerate, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, degenerate, output ready);
endinterface

interface xyzc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [31:0]                 index;
    logic [31:0]                 data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/xyzc_datapath.sv */
// ----------------------------------------------------------------------------
// xyzc_datapath
// Register file, matrix build arithmetic, serial divider and pixel multiply.
// ----------------------------------------------------------------------------
module xyzc_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [2:0]                           cfg_idx,
    input  logic [xyzc_pkg::RegW-1:0]            cfg_val,
    input  xyzc_pkg::dp_cmd_t                    cmd,
    output xyzc_pkg::dp_stat_t                   stat,
    input  logic [xyzc_pkg::PixW-1:0]            pix_x,
    input  logic [xyzc_pkg::PixW-1:0]            pix_y,
    input  logic [xyzc_pkg::PixW-1:0]            pix_z,
    output logic [xyzc_pkg::PixW-1:0]            res_r,
    output logic [xyzc_pkg::PixW-1:0]            res_g,
    output logic [xyzc_pkg::PixW-1:0]            res_b
);

    localparam int RowW  = xyzc_pkg::RowW;
    localparam int NormW = xyzc_pkg::NormW;
    localparam int NumW  = xyzc_pkg::NumW;
    localparam int QuoW  = xyzc_pkg::QuoW;
    localparam int CoefW = xyzc_pkg::CoefW;
    localparam int AccW  = xyzc_pkg::AccW;
    localparam int PixW  = xyzc_pkg::PixW;
    localparam int FracB = xyzc_pkg::CoefFracBits;
    localparam int RemW  = NormW + 1;

    logic [xyzc_pkg::RegW-1:0] regs_reg [xyzc_pkg::NumRegs];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < xyzc_pkg::NumRegs; i++)
                regs_reg[i] <= xyzc_pkg::RegDefaults[i];
        end
        else if (cfg_we)
        begin
            regs_reg[cfg_idx] <= cfg_val;
        end
    end

    // chromaticities with z = 1 - x - y, signed 18 bits
    logic signed [17:0] px [4];
    logic signed [17:0] py [4];
    logic signed [17:0] pz [4];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            px[k] = $signed({2'b00, regs_reg[2*k]});
            py[k] = $signed({2'b00, regs_reg[2*k+1]});
            pz[k] = 18'sd65536 - px[k] - py[k];
        end
    end

    // cross product rows (registered once per build)
    logic signed [RowW-1:0] row_reg [9];
    always_ff @(posedge clk)
    begin
        if (cmd.rows_load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                row_reg[k*3]   <= RowW'(py[(k+1)%3]*pz[(k+2)%3] - pz[(k+1)%3]*py[(k+2)%3]);
                row_reg[k*3+1] <= RowW'(pz[(k+1)%3]*px[(k+2)%3] - px[(k+1)%3]*pz[(k+2)%3]);
                row_reg[k*3+2] <= RowW'(px[(k+1)%3]*py[(k+2)%3] - py[(k+1)%3]*px[(k+2)%3]);
            end
        end
    end

    // white dot product of selected row
    logic [3:0] rbase;
    assign rbase = 4'(cmd.row_sel * 3);
    logic signed [NormW-1:0] norm_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.norm_load)
            norm_reg <= NormW'(row_reg[rbase] * px[3])
                      + NormW'(row_reg[rbase+4'd1] * py[3])
                      + NormW'(row_reg[rbase+4'd2] * pz[3]);
    end
    assign stat.norm_zero    = (norm_reg == '0);
    assign stat.white_y_zero = (regs_reg[xyzc_pkg::REG_WHITE_Y] == '0);

    // numerator row * white_y
    logic signed [NumW-1:0] num;
    assign num = NumW'(row_reg[rbase + 4'(cmd.col_sel)] * py[3]);
    logic [NumW-1:0]  num_mag;
    logic [NormW-1:0] den_mag;
    assign num_mag = num[NumW-1] ? NumW'(-num) : NumW'(num);
    assign den_mag = norm_reg[NormW-1] ? NormW'(-norm_reg) : NormW'(norm_reg);

    // restoring divider, quotient bits from top; floor((num<<24)/den)
    // dividend = num<<24 (77 bits); quotient limited to 39 bits, so the
    // remainder starts from the top 37 bits of the dividend and the remaining
    // dividend bits are fed msb-first, one per step.
    localparam int DvdW = NumW + FracB;
    logic [DvdW-1:0]  dvd_reg;
    logic [RemW-1:0]  rem_reg;
    logic [QuoW:0]    quo_reg;
    logic             neg_reg;
    logic [RemW-1:0]  trial;
    logic [RemW-1:0]  rem_sh;
    assign rem_sh = {rem_reg[RemW-2:0], dvd_reg[DvdW-1]};
    assign trial  = rem_sh - {1'b0, den_mag};

    // dividend head: top DvdW-DivSteps bits, loaded as is (value < den needed)
    localparam int HeadW = DvdW - xyzc_pkg::DivSteps;
    logic [HeadW-1:0] head;
    assign head = HeadW'({num_mag, {FracB{1'b0}}} >> xyzc_pkg::DivSteps);

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= RemW'(head);
            dvd_reg <= DvdW'({num_mag, {FracB{1'b0}}} << HeadW);
            quo_reg <= '0;
            neg_reg <= num[NumW-1] ^ norm_reg[NormW-1];
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_reg << 1;
            if (!trial[RemW-1])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[QuoW-1:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[QuoW-1:0], 1'b0};
            end
        end
    end
    // head >= den means quotient would exceed 40 bits: saturate
    assign stat.div_sat = (NormW'(head) >= den_mag);

    // coefficient store
    logic signed [CoefW-1:0] coef_reg [9];
    logic [CoefW-1:0] qsat;
    assign qsat = (stat.div_sat || quo_reg[QuoW]) ? xyzc_pkg::CoefLimit
                                                  : {1'b0, quo_reg[QuoW-1:0]};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                coef_reg[i] <= '0;
        end
        else if (cmd.coef_store)
        begin
            coef_reg[rbase + 4'(cmd.col_sel)] <= neg_reg ? CoefW'(-qsat) : CoefW'(qsat);
        end
    end

    // pixel multiply: nine products, then sum and shift
    logic signed [PixW:0] pix_reg [3];
    always_ff @(posedge clk)
    begin
        if (cmd.pix_load)
        begin
            pix_reg[0] <= $signed({1'b0, pix_x});
            pix_reg[1] <= $signed({1'b0, pix_y});
            pix_reg[2] <= $signed({1'b0, pix_z});
        end
    end

    logic signed [AccW-1:0] prod_reg [9];
    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
            for (int i = 0; i < 9; i++)
                prod_reg[i] <= AccW'(coef_reg[i] * pix_reg[i%3]);
    end

    logic signed [AccW-1:0] acc [3];
    logic signed [AccW-1:0] low;
    logic [AccW-1:0]        sh [3];
    logic [PixW-1:0]        res_next [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            acc[k] = prod_reg[k*3] + prod_reg[k*3+1] + prod_reg[k*3+2];
        low = '0;
        for (int k = 0; k < 3; k++)
            if (acc[k] < low)
                low = acc[k];
        for (int k = 0; k < 3; k++)
        begin
            sh[k] = (AccW'(acc[k] - low) + (AccW'(1) << (FracB-1))) >> FracB;
            res_next[k] = (sh[k] > AccW'({PixW{1'b1}})) ? {PixW{1'b1}} : sh[k][PixW-1:0];
        end
    end

    logic [PixW-1:0] res_reg [3];
    always_ff @(posedge clk)
    begin
        if (cmd.sum_go)
            for (int k = 0; k < 3; k++)
                res_reg[k] <= res_next[k];
    end
    assign res_r = res_reg[0];
    assign res_g = res_reg[1];
    assign res_b = res_reg[2];

endmodule

/* hw/rtl/xyzc_ctrl.sv */
// ----------------------------------------------------------------------------
// xyzc_ctrl
// Sequencer: matrix build on demand, pixel pass and output handshake.
// ----------------------------------------------------------------------------
module xyzc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_hit,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_degen,
    output xyzc_pkg::dp_cmd_t   cmd,
    input  xyzc_pkg::dp_stat_t  stat
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ROWS, ST_NORM, ST_CHK, ST_DSTART, ST_DIV, ST_STORE,
        ST_MUL, ST_SUM, ST_OUT
    } state_t;

    state_t     state_reg;
    logic       ready_reg;
    logic       bad_reg;
    logic [1:0] row_reg;
    logic [1:0] col_reg;
    logic [5:0] cnt_reg;
    logic       ovalid_reg;
    logic       odeg_reg;

    logic accept;
    logic sum_ok;
    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    // result register free, or being taken this cycle
    assign sum_ok    = !ovalid_reg || out_ready;
    assign out_valid = ovalid_reg;
    assign out_degen = odeg_reg;

    always_comb
    begin
        cmd = '0;
        cmd.row_sel = row_reg;
        cmd.col_sel = col_reg;
        cmd.pix_load   = accept;
        cmd.rows_load  = (state_reg == ST_ROWS);
        cmd.norm_load  = (state_reg == ST_NORM);
        cmd.div_start  = (state_reg == ST_DSTART);
        cmd.div_step   = (state_reg == ST_DIV);
        cmd.coef_store = (state_reg == ST_STORE);
        cmd.mul_go     = (state_reg == ST_MUL);
        cmd.sum_go     = (state_reg == ST_SUM) && sum_ok;
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ready_reg  <= 1'b0;
            bad_reg    <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            odeg_reg   <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            if (cfg_hit)
                ready_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (ready_reg)
                            state_reg <= ST_MUL;
                        else
                        begin
                            row_reg   <= '0;
                            col_reg   <= '0;
                            state_reg <= ST_ROWS;
                        end
                    end
                end
                ST_ROWS:   state_reg <= ST_NORM;
                ST_NORM:   state_reg <= ST_CHK;
                ST_CHK:
                begin
                    if (stat.white_y_zero || stat.norm_zero)
                    begin
                        bad_reg   <= 1'b1;
                        ready_reg <= 1'b1;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        col_reg   <= '0;
                        state_reg <= ST_DSTART;
                    end
                end
                ST_DSTART:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(xyzc_pkg::DivSteps - 1))
                        state_reg <= ST_STORE;
                end
                ST_STORE:
                begin
                    if (col_reg != 2'd2)
                    begin
                        col_reg   <= col_reg + 2'd1;
                        state_reg <= ST_DSTART;
                    end
                    else if (row_reg != 2'd2)
                    begin
                        row_reg   <= row_reg + 2'd1;
                        state_reg <= ST_NORM;
                    end
                    else
                    begin
                        bad_reg   <= 1'b0;
                        ready_reg <= 1'b1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:    state_reg <= ST_SUM;
                // hold while the previous result still waits
                ST_SUM:
                begin
                    if (sum_ok)
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    odeg_reg   <= bad_reg;
                    state_reg  <= ST_IDLE;
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside output step");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STORE) |-> $past(state_reg) == ST_DIV)
        else $error("store without divide");
    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !out_ready) |-> !cmd.sum_go)
        else $error("waiting result overwritten");

endmodule

/* hw/rtl/xyz_to_rgb_gamut_convert.sv */
// ----------------------------------------------------------------------------
// xyz_to_rgb_gamut_convert
// CIE XYZ to linear RGB with configurable primaries and gamut shift.
// ----------------------------------------------------------------------------
//  channel   dir   fields
//  pix_in    in    cie_x, cie_y, cie_z
//  rgb_out   out   red_out, green_out, blue_out, degenerate
//  cfg       in    index, data (register write)
//
//  With the matrix cached a pixel goes through the multiply, sum and output
//  steps; the next pixel is taken only after its result is raised.
//  After reset or a register write, the next pixel first builds the matrix:
//  row set-up, then nine serial divisions unless the matrix is degenerate.
//  A result waiting on rgb_out holds the next request at its sum step.
//  Reset restores default chromaticities and drops the cached matrix.
// ----------------------------------------------------------------------------
module xyz_to_rgb_gamut_convert (
    input  logic           clk,
    input  logic           rst_n,
    xyzc_pix_if.sink       pix_in,
    xyzc_rgb_if.source     rgb_out,
    xyzc_cfg_if.sink       cfg
);

    xyzc_pkg::dp_cmd_t  cmd;
    xyzc_pkg::dp_stat_t stat;
    logic cfg_we;
    logic degen;
    logic [xyzc_pkg::PixW-1:0] r, g, b;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && (cfg.index < 32'(xyzc_pkg::NumRegs));

    xyzc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_hit   (cfg_we),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .out_valid (rgb_out.valid),
        .out_ready (rgb_out.ready),
        .out_degen (degen),
        .cmd       (cmd),
        .stat      (stat)
    );

    xyzc_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_idx (cfg.index[2:0]),
        .cfg_val (cfg.data[xyzc_pkg::RegW-1:0]),
        .cmd     (cmd),
        .stat    (stat),
        .pix_x   (pix_in.cie_x),
        .pix_y   (pix_in.cie_y),
        .pix_z   (pix_in.cie_z),
        .res_r   (r),
        .res_g   (g),
        .res_b   (b)
    );

    // degenerate matrix forces zero colour
    assign rgb_out.degenerate = degen;
    assign rgb_out.red_out    = degen ? '0 : r;
    assign rgb_out.green_out  = degen ? '0 : g;
    assign rgb_out.blue_out   = degen ? '0 : b;

endmodule
